// ===== hw/rtl/ftpt_pkg.sv =====
// Shared types and constants of the text pre-tokenizer.
// Beat payloads, byte codes and byte-class helpers; no dependencies.
package ftpt_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
	} text_beat_t;

	typedef struct packed {
		logic [7:0] word_byte;
		logic       word_end;
	} word_beat_t;

	// Result of one scan step toward the output register.
	typedef struct packed {
		logic       valid;
		word_beat_t beat;
	} scan_result_t;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_PERIOD  = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_upper(input logic [7:0] b);
		return (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return is_upper(b) || ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return is_upper(b) ? (b + CASE_DELTA) : b;
	endfunction

endpackage

// ===== hw/rtl/ftpt_stream_if.sv =====
// Valid/ready stream channel of the text pre-tokenizer.
// Payload type is set per instance from ftpt_pkg beat types.
interface ftpt_stream_if #(
	parameter type T = ftpt_pkg::text_beat_t
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ftpt_scan.sv =====
// Word scanner: mode machine with one held byte and a word length count.
// Uses ftpt_pkg byte classes; one accepted text beat per cycle in which step is high.
module ftpt_scan #(
	parameter int MAX_WORD_LEN = 2046,
	parameter int LEN_W        = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            text_byte,
	output ftpt_pkg::scan_result_t result
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_DOLLAR,
		MODE_NUM,
		MODE_ALPHA,
		MODE_DONE
	} mode_t;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	mode_t            mode_q, mode_d;
	logic [7:0]       held_q, held_d;
	logic [LEN_W-1:0] len_q, len_d;

	logic       do_ext;
	mode_t      ext_mode;
	logic [7:0] ext_byte;
	logic [7:0] low_byte;

	assign low_byte = ftpt_pkg::to_lower(text_byte);

	// Decide whether the byte continues the held word.
	always_comb begin
		do_ext   = 1'b0;
		ext_mode = mode_q;
		ext_byte = text_byte;
		case (mode_q)
			MODE_NUM: begin
				if (ftpt_pkg::is_digit(text_byte) || text_byte == ftpt_pkg::CH_COMMA ||
						text_byte == ftpt_pkg::CH_PERIOD) begin
					do_ext = 1'b1;
				end else if (text_byte == ftpt_pkg::CH_PERCENT) begin
					do_ext   = 1'b1;
					ext_mode = MODE_DONE;
				end
			end
			MODE_ALPHA: begin
				if (ftpt_pkg::is_letter(text_byte) || text_byte == ftpt_pkg::CH_APOS ||
						text_byte == ftpt_pkg::CH_HYPHEN || text_byte == ftpt_pkg::CH_SLASH) begin
					do_ext   = 1'b1;
					ext_byte = low_byte;
				end
			end
			MODE_DOLLAR: begin
				if (ftpt_pkg::is_digit(text_byte)) begin
					do_ext   = 1'b1;
					ext_mode = MODE_NUM;
				end
			end
			default: begin
				do_ext = 1'b0;
			end
		endcase
	end

	always_comb begin
		mode_d                = mode_q;
		held_d                = held_q;
		len_d                 = len_q;
		result.valid          = 1'b0;
		result.beat.word_byte = held_q;
		result.beat.word_end  = 1'b1;
		if (text_byte == ftpt_pkg::CH_NUL) begin
			// Flush the held byte and return to reset.
			result.valid = (mode_q != MODE_IDLE);
			mode_d       = MODE_IDLE;
			held_d       = '0;
			len_d        = '0;
		end else if (do_ext) begin
			// Past the length limit, drop the byte but keep the mode change.
			if (len_q < LEN_MAX) begin
				result.valid         = 1'b1;
				result.beat.word_end = 1'b0;
				held_d               = ext_byte;
				len_d                = len_q + LEN_ONE;
			end
			mode_d = ext_mode;
		end else begin
			result.valid = (mode_q != MODE_IDLE);
			if (ftpt_pkg::is_space(text_byte)) begin
				mode_d = MODE_IDLE;
				held_d = '0;
				len_d  = '0;
			end else begin
				if (text_byte == ftpt_pkg::CH_DOLLAR) begin
					mode_d = MODE_DOLLAR;
				end else if (ftpt_pkg::is_digit(text_byte)) begin
					mode_d = MODE_NUM;
				end else if (ftpt_pkg::is_letter(text_byte)) begin
					mode_d = MODE_ALPHA;
				end else begin
					mode_d = MODE_DONE;
				end
				held_d = low_byte;
				len_d  = LEN_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= '0;
			len_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			held_q <= held_d;
			len_q  <= len_d;
		end
	end

`ifndef ASSERT_OFF
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("word length above limit");

	a_idle_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (len_q == '0))
		else $error("idle with nonzero word length");

	a_busy_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (len_q != '0))
		else $error("held word with zero length");

	a_nul_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(step && text_byte == ftpt_pkg::CH_NUL) |=> (mode_q == MODE_IDLE))
		else $error("end of text did not return to idle");
`endif

endmodule

// ===== hw/rtl/ftpt_out_reg.sv =====
// Output register of the text pre-tokenizer word channel.
// Holds one result beat; uses ftpt_pkg beat types.
module ftpt_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ftpt_pkg::word_beat_t  beat,
	input  logic                  sink_ready,
	output logic                  can_take,
	output logic                  valid,
	output ftpt_pkg::word_beat_t  data
);

	logic                 valid_q;
	ftpt_pkg::word_beat_t beat_q;

	// A new beat may enter when the register is empty or drains this cycle.
	assign can_take = !valid_q || sink_ready;
	assign valid    = valid_q;
	assign data     = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (sink_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= beat;
		end
	end

endmodule

// ===== hw/rtl/finance_text_pre_tokenizer_core.sv =====
// Top level of the text pre-tokenizer.
// Uses ftpt_pkg, ftpt_stream_if, ftpt_scan and ftpt_out_reg.

// Takes one text byte per cycle and gives at most one word byte per byte
// taken, with word_end on the last byte of each word. Whitespace is dropped,
// letters are lowercased, and a zero byte flushes the held byte and resets.
// Each word byte is held back in the scanner until the byte that ends or
// continues its word is taken, and then passes through the output register;
// a byte is taken in every cycle in which the output register is empty or is
// being emptied, so the rate is one byte per cycle whenever the downstream
// side keeps up. Bytes beyond MAX_WORD_LEN in a word are taken and dropped.
module finance_text_pre_tokenizer_core #(
	parameter int MAX_WORD_LEN = 2046
) (
	input  logic          clk,
	input  logic          arst_n,
	ftpt_stream_if.sink   text,
	ftpt_stream_if.source words
);

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

	ftpt_pkg::scan_result_t result;
	ftpt_pkg::text_beat_t   text_beat;
	ftpt_pkg::word_beat_t   word_beat;
	logic                   can_take;
	logic                   step;

	assign text_beat  = text.data;
	assign text.ready = can_take;
	assign step       = text.valid && can_take;
	assign words.data = word_beat;

	ftpt_scan #(
		.MAX_WORD_LEN (MAX_WORD_LEN),
		.LEN_W        (LEN_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (text_beat.text_byte),
		.result    (result)
	);

	ftpt_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step && result.valid),
		.beat       (result.beat),
		.sink_ready (words.ready),
		.can_take   (can_take),
		.valid      (words.valid),
		.data       (word_beat)
	);

endmodule

// ===== dv/tb_finance_text_pre_tokenizer_core.sv =====
// Self-checking testbench of finance_text_pre_tokenizer_core.
// Needs ftpt_pkg and ftpt_stream_if; predicts each word beat from the text bytes
// sent and compares it with what the core gives, with and without random idling on both sides.
module tb_finance_text_pre_tokenizer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_LIMIT    = 2046;
	localparam int STALL_LIMIT   = 4000;
	localparam int SHOWN_ERRORS  = 10;
	localparam int ITEMS_PER_RUN = 530;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_DOLLAR,
		SCAN_NUMBER,
		SCAN_ALPHA,
		SCAN_CLOSED
	} scan_state_e;

	logic clk;
	logic arst_n;

	ftpt_stream_if #(.T(ftpt_pkg::text_beat_t)) text_ch ();
	ftpt_stream_if #(.T(ftpt_pkg::word_beat_t)) word_ch ();

	finance_text_pre_tokenizer_core #(
		.MAX_WORD_LEN(WORD_LIMIT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.words (word_ch)
	);

	// predicted tokenizer state
	scan_state_e scan_state;
	logic [7:0]  held_char;
	int          held_len;

	ftpt_pkg::word_beat_t expected_words[$];
	int                   error_count;
	int                   bytes_sent;
	int                   idle_cycles;
	int                   send_idle_pct;
	int                   recv_idle_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		word_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic char_is_blank(input logic [7:0] b);
		return (b == ftpt_pkg::CH_SPACE) || (b >= ftpt_pkg::CH_TAB && b <= ftpt_pkg::CH_CR);
	endfunction

	function automatic logic char_is_numeral(input logic [7:0] b);
		return b >= ftpt_pkg::CH_ZERO && b <= ftpt_pkg::CH_NINE;
	endfunction

	function automatic logic char_is_capital(input logic [7:0] b);
		return b >= ftpt_pkg::CH_UPPER_A && b <= ftpt_pkg::CH_UPPER_Z;
	endfunction

	function automatic logic char_is_alpha(input logic [7:0] b);
		return char_is_capital(b) || (b >= ftpt_pkg::CH_LOWER_A && b <= ftpt_pkg::CH_LOWER_Z);
	endfunction

	function automatic logic [7:0] random_letter();
		return ($urandom_range(1) ? ftpt_pkg::CH_UPPER_A : ftpt_pkg::CH_LOWER_A)
			+ 8'($urandom_range(25));
	endfunction

	task automatic queue_word_byte(input logic [7:0] b, input logic last);
		ftpt_pkg::word_beat_t w;
		w.word_byte = b;
		w.word_end  = last;
		expected_words.push_back(w);
	endtask

	task automatic clear_scan();
		scan_state = SCAN_IDLE;
		held_char  = 8'h00;
		held_len   = 0;
	endtask

	// Keep b in the current word unless the word is full; then drop it.
	task automatic grow_word(input logic [7:0] b, input scan_state_e next_state);
		if (held_len < WORD_LIMIT) begin
			queue_word_byte(held_char, 1'b0);
			held_char = b;
			held_len++;
		end
		scan_state = next_state;
	endtask

	task automatic tokenize_byte(input logic [7:0] b);
		logic [7:0] folded;
		folded = char_is_capital(b) ? b + ftpt_pkg::CASE_DELTA : b;
		if (b == ftpt_pkg::CH_NUL) begin
			if (scan_state != SCAN_IDLE)
				queue_word_byte(held_char, 1'b1);
			clear_scan();
			return;
		end
		case (scan_state)
			SCAN_NUMBER: begin
				if (char_is_numeral(b) || b == ftpt_pkg::CH_COMMA ||
						b == ftpt_pkg::CH_PERIOD) begin
					grow_word(b, SCAN_NUMBER);
					return;
				end
				if (b == ftpt_pkg::CH_PERCENT) begin
					grow_word(b, SCAN_CLOSED);
					return;
				end
			end
			SCAN_ALPHA: begin
				if (char_is_alpha(b) || b == ftpt_pkg::CH_APOS || b == ftpt_pkg::CH_HYPHEN ||
						b == ftpt_pkg::CH_SLASH) begin
					grow_word(folded, SCAN_ALPHA);
					return;
				end
			end
			SCAN_DOLLAR: begin
				if (char_is_numeral(b)) begin
					grow_word(b, SCAN_NUMBER);
					return;
				end
			end
			default: ;
		endcase
		// the held word ends here and b, unless it is blank, opens the next one
		if (scan_state != SCAN_IDLE)
			queue_word_byte(held_char, 1'b1);
		if (char_is_blank(b)) begin
			clear_scan();
			return;
		end
		if (b == ftpt_pkg::CH_DOLLAR)
			scan_state = SCAN_DOLLAR;
		else if (char_is_numeral(b))
			scan_state = SCAN_NUMBER;
		else if (char_is_alpha(b))
			scan_state = SCAN_ALPHA;
		else
			scan_state = SCAN_CLOSED;
		held_char = folded;
		held_len  = 1;
	endtask

	// Enter and leave at a falling edge; valid stays high for a following beat.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid          <= 1'b1;
		text_ch.data.text_byte <= b;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		tokenize_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every predicted word byte has come out.
	task automatic wait_for_drain();
		text_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_words.size() != 0);
	endtask

	task automatic report_error(input string kind, input ftpt_pkg::word_beat_t want,
			input ftpt_pkg::word_beat_t got);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("%0t %s: expected byte %02h end %0b, got byte %02h end %0b",
				$realtime, kind, want.word_byte, want.word_end, got.word_byte, got.word_end);
	endtask

	always @(posedge clk) begin
		ftpt_pkg::word_beat_t got;
		ftpt_pkg::word_beat_t want;
		if (arst_n && word_ch.valid && word_ch.ready) begin
			got = word_ch.data;
			if (expected_words.size() == 0) begin
				want = '0;
				report_error("unexpected beat", want, got);
			end else begin
				want = expected_words.pop_front();
				if (got.word_byte !== want.word_byte || got.word_end !== want.word_end)
					report_error("mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (word_ch.valid && word_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d word bytes outstanding",
				idle_cycles, expected_words.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		string      phrase;
		logic [7:0] seq[$];
		phrase = "$0,9.5% aZ-b'z/ $$x 9%%";
		for (int i = 0; i < phrase.len(); i++)
			seq.push_back(phrase[i]);
		seq.push_back(ftpt_pkg::CH_TAB);
		seq.push_back(8'h7F);
		seq.push_back(8'hFF);
		seq.push_back(8'h80);
		seq.push_back(ftpt_pkg::CH_NUL);   // flush with a byte held
		seq.push_back(ftpt_pkg::CH_NUL);   // flush with nothing held
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_overlong();
		for (int i = 0; i < WORD_LIMIT + 4; i++)
			send_byte(ftpt_pkg::CH_ZERO + 8'($urandom_range(9)));
		send_byte(ftpt_pkg::CH_PERCENT);
		send_byte(ftpt_pkg::CH_SPACE);
		for (int i = 0; i < WORD_LIMIT + 2; i++)
			send_byte(random_letter());
		send_byte(ftpt_pkg::CH_HYPHEN);
		send_byte(ftpt_pkg::CH_NUL);
	endtask

	task automatic send_number_word();
		int n;
		if ($urandom_range(2) == 0)
			send_byte(ftpt_pkg::CH_DOLLAR);
		send_byte(ftpt_pkg::CH_ZERO + 8'($urandom_range(9)));
		n = $urandom_range(10);
		repeat (n) begin
			case ($urandom_range(5))
				0: send_byte(ftpt_pkg::CH_COMMA);
				1: send_byte(ftpt_pkg::CH_PERIOD);
				default: send_byte(ftpt_pkg::CH_ZERO + 8'($urandom_range(9)));
			endcase
		end
		if ($urandom_range(3) == 0)
			send_byte(ftpt_pkg::CH_PERCENT);
	endtask

	task automatic send_alpha_word();
		int n;
		send_byte(random_letter());
		n = $urandom_range(10);
		repeat (n) begin
			case ($urandom_range(7))
				0: send_byte(ftpt_pkg::CH_APOS);
				1: send_byte(ftpt_pkg::CH_HYPHEN);
				2: send_byte(ftpt_pkg::CH_SLASH);
				default: send_byte(random_letter());
			endcase
		end
	endtask

	task automatic send_other_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (char_is_blank(b) || char_is_numeral(b) || char_is_alpha(b));
		send_byte(b);
	endtask

	task automatic send_blank();
		int pick;
		pick = $urandom_range(9, 14);
		send_byte(pick == 14 ? ftpt_pkg::CH_SPACE : 8'(pick));
	endtask

	task automatic test_random_text(input int items);
		int first;
		int pick;
		first = bytes_sent;
		while (bytes_sent - first < items) begin
			pick = $urandom_range(99);
			if (pick < 30)
				send_number_word();
			else if (pick < 60)
				send_alpha_word();
			else if (pick < 70)
				send_other_byte();
			else if (pick < 76) begin
				// lone dollar: the next byte, unless it is blank, opens its own word
				send_byte(ftpt_pkg::CH_DOLLAR);
				case ($urandom_range(3))
					0: send_alpha_word();
					1: send_other_byte();
					2: send_byte(ftpt_pkg::CH_DOLLAR);
					default: send_blank();
				endcase
			end else if (pick < 80)
				send_byte(ftpt_pkg::CH_NUL);
			else if (pick < 90)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			if ($urandom_range(9) < 7)
				repeat ($urandom_range(1, 2)) send_blank();
		end
	endtask

	initial begin
		arst_n                 = 1'b0;
		text_ch.valid          = 1'b0;
		text_ch.data           = '0;
		word_ch.ready          = 1'b0;
		error_count            = 0;
		bytes_sent             = 0;
		idle_cycles            = 0;
		send_idle_pct          = 20;
		recv_idle_pct          = 71;
		clear_scan();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_text(ITEMS_PER_RUN);
		wait_for_drain();

		send_idle_pct = 71;
		recv_idle_pct = 20;
		test_random_text(ITEMS_PER_RUN);
		wait_for_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_overlong();
		test_random_text(ITEMS_PER_RUN);

		wait_for_drain();
		repeat (8) @(negedge clk);
		if (error_count == 0 && expected_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
